FILE: rtl/wct_pkg.sv
// ----------------------------------------------------------------------------
// wct_pkg
// Shared sizes, codes, state types and cell interface structs for the
// weighted choice table.
// ----------------------------------------------------------------------------
package wct_pkg;

  localparam int MAX_CHOICES = 8;
  localparam int WEIGHT_BITS = 16;

  localparam int IDX_W   = (MAX_CHOICES > 1) ? $clog2(MAX_CHOICES) : 1;
  localparam int CNT_W   = $clog2(MAX_CHOICES + 1);
  localparam int TOTAL_W =
    $clog2(longint'(MAX_CHOICES) * ((longint'(1) << WEIGHT_BITS) - 1) + 1);
  localparam int K_W     = $clog2(WEIGHT_BITS);
  localparam int STEP_W  = $clog2(WEIGHT_BITS);

  // fixed port widths
  localparam int IN_WEIGHT_W = 16;
  localparam int SEL_W       = 19;
  localparam int IDX_OUT_W   = 3;
  localparam int TOTAL_OUT_W = 19;
  localparam int DIV_OUT_W   = 16;
  localparam int STATUS_W    = 2;
  localparam int OPT_W       = 4;
  localparam int ADDR_W      = 3;
  localparam int DATA_W      = 32;

  localparam int CMP_W  = (SEL_W > TOTAL_W) ? SEL_W : TOTAL_W;
  localparam int CMPO_W = (OPT_W > CNT_W) ? OPT_W : CNT_W;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_RANGE    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

  localparam logic             REG_OPTION_COUNT = 1'b0;
  localparam logic [OPT_W-1:0] OPT_RESET        = 4'd8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GCD_GO,
    ST_GCD_WAIT,
    ST_DIV,
    ST_COMMIT,
    ST_SUM,
    ST_WALK
  } state_t;

  typedef enum logic [1:0] {
    G_IDLE,
    G_TWOS,
    G_ODD,
    G_LOOP
  } gcd_state_t;

  typedef struct packed {
    logic               act;
    logic               hit;
    logic [IDX_W-1:0]   idx;
    logic [TOTAL_W-1:0] val;
  } link_t;

  typedef struct packed {
    logic                   div_init;
    logic                   div_step;
    logic                   commit;
    logic                   sum_mode;
    logic                   loaded;
    logic [CNT_W-1:0]       count;
    logic [WEIGHT_BITS-1:0] divisor;
    logic [WEIGHT_BITS-1:0] wdata;
  } cell_ctl_t;

endpackage

FILE: rtl/wct_gcd.sv
// ----------------------------------------------------------------------------
// wct_gcd
// Iterative binary gcd unit, one shift or subtract per cycle.
// ----------------------------------------------------------------------------
module wct_gcd
  import wct_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [WEIGHT_BITS-1:0] a_in,
  input  logic [WEIGHT_BITS-1:0] b_in,
  output logic                   done,
  output logic [WEIGHT_BITS-1:0] result
);

  gcd_state_t             state_r, state_nxt;
  logic [WEIGHT_BITS-1:0] a_r, a_nxt;
  logic [WEIGHT_BITS-1:0] b_r, b_nxt;
  logic [K_W-1:0]         k_r, k_nxt;
  logic                   done_r, done_nxt;
  logic [WEIGHT_BITS-1:0] res_r, res_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= G_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    k_r   <= k_nxt;
    res_r <= res_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    k_nxt     = k_r;
    res_nxt   = res_r;
    done_nxt  = 1'b0;
    case (state_r)
      G_IDLE: begin
        if (start) begin
          if (a_in == '0) begin
            res_nxt  = b_in;
            done_nxt = 1'b1;
          end else if (b_in == '0) begin
            res_nxt  = a_in;
            done_nxt = 1'b1;
          end else begin
            a_nxt     = a_in;
            b_nxt     = b_in;
            k_nxt     = '0;
            state_nxt = G_TWOS;
          end
        end
      end
      G_TWOS: begin
        // strip common factors of two
        if (!a_r[0] && !b_r[0]) begin
          a_nxt = a_r >> 1;
          b_nxt = b_r >> 1;
          k_nxt = k_r + K_W'(1);
        end else begin
          state_nxt = G_ODD;
        end
      end
      G_ODD: begin
        if (!a_r[0]) begin
          a_nxt = a_r >> 1;
        end else begin
          state_nxt = G_LOOP;
        end
      end
      G_LOOP: begin
        if (b_r == '0) begin
          res_nxt   = a_r << k_r;
          done_nxt  = 1'b1;
          state_nxt = G_IDLE;
        end else if (!b_r[0]) begin
          b_nxt = b_r >> 1;
        end else if (a_r > b_r) begin
          a_nxt = b_r;
          b_nxt = a_r - b_r;
        end else begin
          b_nxt = b_r - a_r;
        end
      end
      default: begin
        state_nxt = G_IDLE;
      end
    endcase
  end

  assign done   = done_r;
  assign result = res_r;

endmodule

FILE: rtl/wct_cell.sv
// ----------------------------------------------------------------------------
// wct_cell
// One table entry: staged weight, serial divider, stored weight, and one
// registered stage of the sum and sample walk chain.
// ----------------------------------------------------------------------------
module wct_cell
  import wct_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [IDX_W-1:0]       cell_idx,
  input  cell_ctl_t              ctl,
  input  logic                   stage_we,
  input  link_t                  link_in,
  output link_t                  link_out,
  output logic [WEIGHT_BITS-1:0] stage_q
);

  logic [WEIGHT_BITS-1:0] stage_r, stage_nxt;
  logic [WEIGHT_BITS-1:0] rem_r, rem_nxt;
  logic [WEIGHT_BITS-1:0] stored_r, stored_nxt;
  link_t                  link_r, link_nxt;

  logic [WEIGHT_BITS:0]   rem_sh;
  logic                   rem_ge;
  logic [WEIGHT_BITS-1:0] w;
  logic [TOTAL_W-1:0]     wx;
  logic                   in_table;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_r.act <= 1'b0;
    end else begin
      link_r <= link_nxt;
    end
  end

  always_ff @(posedge clk) begin
    stage_r  <= stage_nxt;
    rem_r    <= rem_nxt;
    stored_r <= stored_nxt;
  end

  always_comb begin
    // restoring division, quotient shifts into the staged weight
    rem_sh = {rem_r, stage_r[WEIGHT_BITS-1]};
    rem_ge = rem_sh >= {1'b0, ctl.divisor};

    stage_nxt = stage_r;
    if (stage_we) begin
      stage_nxt = ctl.wdata;
    end else if (ctl.div_step) begin
      stage_nxt = {stage_r[WEIGHT_BITS-2:0], rem_ge};
    end

    rem_nxt = rem_r;
    if (ctl.div_init) begin
      rem_nxt = '0;
    end else if (ctl.div_step) begin
      rem_nxt = rem_ge ? WEIGHT_BITS'(rem_sh - {1'b0, ctl.divisor})
                       : rem_sh[WEIGHT_BITS-1:0];
    end

    stored_nxt = ctl.commit ? stage_r : stored_r;

    w        = ctl.loaded ? stored_r : WEIGHT_BITS'(1);
    wx       = TOTAL_W'(w);
    in_table = CNT_W'(cell_idx) < ctl.count;

    link_nxt = link_in;
    if (ctl.sum_mode) begin
      if (in_table) begin
        link_nxt.val = link_in.val + TOTAL_W'(stored_r);
      end
    end else if (!link_in.hit) begin
      if (wx > link_in.val) begin
        link_nxt.hit = 1'b1;
        link_nxt.idx = cell_idx;
      end else begin
        link_nxt.val = link_in.val - wx;
      end
    end
  end

  assign link_out = link_r;
  assign stage_q  = stage_r;

endmodule

FILE: rtl/weighted_choice_table.sv
// ----------------------------------------------------------------------------
// weighted_choice_table
// Weight table with gcd normalization and selector-driven index draw,
// built as a row of entry cells with a shared gcd unit.
//
// channel   direction  handshake                       payload
// input     in         start && !busy                  in_opcode .. in_selector
// result    out        out_valid, one cycle            out_chosen_index .. out_status
// config    in/out     psel&penable&pwrite&pready      paddr, pwdata, prdata
//
// plain load or rejected sample: result the cycle after the transfer, never busy
// sample: busy while the token walks one cell per cycle through the cell row
// last load: per staged entry a gcd start and a gcd wait, then the serial
//   divider steps, a commit, and a sum walk through the cell row
// reset: synchronous, no clearing pass; the receiver cannot stall
// ----------------------------------------------------------------------------
module weighted_choice_table
  import wct_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic                   in_opcode,
  input  logic [IN_WEIGHT_W-1:0] in_weight_value,
  input  logic                   in_last_weight,
  input  logic [SEL_W-1:0]       in_selector,
  output logic                   out_valid,
  output logic [IDX_OUT_W-1:0]   out_chosen_index,
  output logic [TOTAL_OUT_W-1:0] out_total_weight,
  output logic [DIV_OUT_W-1:0]   out_common_divisor,
  output logic [STATUS_W-1:0]    out_status,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [ADDR_W-1:0]      paddr,
  input  logic [DATA_W-1:0]      pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready
);

  state_t                 state_r, state_nxt;
  logic [CNT_W-1:0]       stage_cnt_r, stage_cnt_nxt;
  logic [CNT_W-1:0]       load_cnt_r, load_cnt_nxt;
  logic                   loaded_r, loaded_nxt;
  logic [TOTAL_W-1:0]     total_r, total_nxt;
  logic [WEIGHT_BITS-1:0] divisor_r, divisor_nxt;
  logic [OPT_W-1:0]       opt_r, opt_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  logic [STEP_W-1:0]      step_r, step_nxt;
  logic [WEIGHT_BITS-1:0] g_r, g_nxt;
  logic [STATUS_W-1:0]    hold_r, hold_nxt;
  link_t                  inj_r, inj_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [IDX_OUT_W-1:0]   out_idx_r, out_idx_nxt;
  logic [TOTAL_OUT_W-1:0] out_total_r, out_total_nxt;
  logic [DIV_OUT_W-1:0]   out_div_r, out_div_nxt;
  logic [STATUS_W-1:0]    out_status_r, out_status_nxt;

  cell_ctl_t              cell_ctl;
  logic [MAX_CHOICES-1:0] stage_we;
  link_t                  chain_in  [MAX_CHOICES];
  link_t                  chain_out [MAX_CHOICES];
  logic [WEIGHT_BITS-1:0] stage_q   [MAX_CHOICES];
  link_t                  tail;

  logic                   gcd_start;
  logic                   gcd_done;
  logic [WEIGHT_BITS-1:0] gcd_result;

  logic [CNT_W-1:0]       def_cnt;
  logic [TOTAL_W-1:0]     total_cur;
  logic                   stage_full;
  logic [CNT_W-1:0]       cnt_after;
  logic [STATUS_W-1:0]    load_status;
  logic                   sel_bad;
  logic                   last_entry;
  logic                   cfg_we;

  // cell row
  assign chain_in[0] = inj_r;
  for (genvar i = 0; i < MAX_CHOICES; i++) begin : g_cell
    if (i > 0) begin : g_link
      assign chain_in[i] = chain_out[i-1];
    end
    wct_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (IDX_W'(i)),
      .ctl      (cell_ctl),
      .stage_we (stage_we[i]),
      .link_in  (chain_in[i]),
      .link_out (chain_out[i]),
      .stage_q  (stage_q[i])
    );
  end
  assign tail = chain_out[MAX_CHOICES-1];

  wct_gcd u_gcd (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (gcd_start),
    .a_in   (g_r),
    .b_in   (stage_q[idx_r]),
    .done   (gcd_done),
    .result (gcd_result)
  );

  // config port
  assign cfg_we  = psel & penable & pwrite & pready;
  assign pready  = 1'b1;
  assign prdata  = (paddr[2] == REG_OPTION_COUNT) ? DATA_W'(opt_r) : '0;
  assign opt_nxt = (cfg_we && paddr[2] == REG_OPTION_COUNT) ? pwdata[OPT_W-1:0] : opt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      stage_cnt_r <= '0;
      load_cnt_r  <= '0;
      loaded_r    <= 1'b0;
      total_r     <= '0;
      divisor_r   <= WEIGHT_BITS'(1);
      opt_r       <= OPT_RESET;
      idx_r       <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
      inj_r.act   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      stage_cnt_r <= stage_cnt_nxt;
      load_cnt_r  <= load_cnt_nxt;
      loaded_r    <= loaded_nxt;
      total_r     <= total_nxt;
      divisor_r   <= divisor_nxt;
      opt_r       <= opt_nxt;
      idx_r       <= idx_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
      inj_r       <= inj_nxt;
    end
  end

  always_ff @(posedge clk) begin
    g_r          <= g_nxt;
    hold_r       <= hold_nxt;
    out_idx_r    <= out_idx_nxt;
    out_total_r  <= out_total_nxt;
    out_div_r    <= out_div_nxt;
    out_status_r <= out_status_nxt;
  end

  always_comb begin
    def_cnt = (CMPO_W'(opt_r) > CMPO_W'(MAX_CHOICES)) ? CNT_W'(MAX_CHOICES)
                                                       : CNT_W'(opt_r);
    total_cur   = loaded_r ? total_r : TOTAL_W'(def_cnt);
    stage_full  = stage_cnt_r == CNT_W'(MAX_CHOICES);
    cnt_after   = stage_full ? stage_cnt_r : stage_cnt_r + CNT_W'(1);
    load_status = stage_full ? STATUS_OVERFLOW : STATUS_OK;
    sel_bad     = (total_cur == '0) || (CMP_W'(in_selector) >= CMP_W'(total_cur));
    last_entry  = (CNT_W'(idx_r) + CNT_W'(1)) == load_cnt_r;

    state_nxt     = state_r;
    stage_cnt_nxt = stage_cnt_r;
    load_cnt_nxt  = load_cnt_r;
    loaded_nxt    = loaded_r;
    total_nxt     = total_r;
    divisor_nxt   = divisor_r;
    idx_nxt       = idx_r;
    step_nxt      = step_r;
    g_nxt         = g_r;
    hold_nxt      = hold_r;
    inj_nxt       = '0;
    stage_we      = '0;
    gcd_start     = 1'b0;

    cell_ctl          = '0;
    cell_ctl.sum_mode = state_r == ST_SUM;
    cell_ctl.loaded   = loaded_r;
    cell_ctl.count    = load_cnt_r;
    cell_ctl.divisor  = divisor_r;
    cell_ctl.wdata    = WEIGHT_BITS'(in_weight_value);

    out_valid_nxt  = 1'b0;
    out_idx_nxt    = out_idx_r;
    out_total_nxt  = out_total_r;
    out_div_nxt    = out_div_r;
    out_status_nxt = out_status_r;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_opcode == OP_LOAD) begin
            if (!stage_full) begin
              stage_we[stage_cnt_r[IDX_W-1:0]] = 1'b1;
            end
            if (in_last_weight) begin
              load_cnt_nxt  = cnt_after;
              stage_cnt_nxt = '0;
              g_nxt         = '0;
              idx_nxt       = '0;
              hold_nxt      = load_status;
              state_nxt     = ST_GCD_GO;
            end else begin
              stage_cnt_nxt  = cnt_after;
              out_valid_nxt  = 1'b1;
              out_idx_nxt    = '0;
              out_total_nxt  = TOTAL_OUT_W'(total_cur);
              out_div_nxt    = DIV_OUT_W'(divisor_r);
              out_status_nxt = load_status;
            end
          end else if (sel_bad) begin
            out_valid_nxt  = 1'b1;
            out_idx_nxt    = '0;
            out_total_nxt  = TOTAL_OUT_W'(total_cur);
            out_div_nxt    = DIV_OUT_W'(divisor_r);
            out_status_nxt = STATUS_RANGE;
          end else begin
            inj_nxt.act = 1'b1;
            inj_nxt.val = TOTAL_W'(in_selector);
            state_nxt   = ST_WALK;
          end
        end
      end
      ST_GCD_GO: begin
        gcd_start = 1'b1;
        state_nxt = ST_GCD_WAIT;
      end
      ST_GCD_WAIT: begin
        if (gcd_done) begin
          g_nxt = gcd_result;
          if (last_entry) begin
            divisor_nxt       = (gcd_result == '0) ? WEIGHT_BITS'(1) : gcd_result;
            cell_ctl.div_init = 1'b1;
            step_nxt          = '0;
            state_nxt         = ST_DIV;
          end else begin
            idx_nxt   = idx_r + IDX_W'(1);
            state_nxt = ST_GCD_GO;
          end
        end
      end
      ST_DIV: begin
        cell_ctl.div_step = 1'b1;
        step_nxt          = step_r + STEP_W'(1);
        if (step_r == STEP_W'(WEIGHT_BITS - 1)) begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        cell_ctl.commit = 1'b1;
        inj_nxt.act     = 1'b1;
        state_nxt       = ST_SUM;
      end
      ST_SUM: begin
        if (tail.act) begin
          total_nxt      = tail.val;
          loaded_nxt     = 1'b1;
          out_valid_nxt  = 1'b1;
          out_idx_nxt    = '0;
          out_total_nxt  = TOTAL_OUT_W'(tail.val);
          out_div_nxt    = DIV_OUT_W'(divisor_r);
          out_status_nxt = hold_r;
          state_nxt      = ST_IDLE;
        end
      end
      ST_WALK: begin
        if (tail.act) begin
          out_valid_nxt  = 1'b1;
          out_idx_nxt    = IDX_OUT_W'(tail.idx);
          out_total_nxt  = TOTAL_OUT_W'(total_cur);
          out_div_nxt    = DIV_OUT_W'(divisor_r);
          out_status_nxt = STATUS_OK;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy               = state_r != ST_IDLE;
  assign out_valid          = out_valid_r;
  assign out_chosen_index   = out_idx_r;
  assign out_total_weight   = out_total_r;
  assign out_common_divisor = out_div_r;
  assign out_status         = out_status_r;

  // chain token only leaves the row during a sum or sample walk
  a_tail_mode: assert property (@(posedge clk) disable iff (!rst_n)
    tail.act |-> (state_r == ST_SUM || state_r == ST_WALK))
    else $error("chain token outside sum or walk");

  // every transfer ends in a result strobe or a long operation
  a_accept_resp: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (out_valid || busy))
    else $error("accepted item produced nothing");

  a_stage_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    stage_cnt_r <= CNT_W'(MAX_CHOICES))
    else $error("staging count past table size");

  a_divisor_nz: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (divisor_r != '0))
    else $error("zero divisor during division");

endmodule

FILE: verif/weighted_choice_table_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// weighted_choice_table_tb
// Self-checking bench for the weighted choice table. Load and sample commands
// go from a queue to a clocked driver. An in-bench table model predicts every
// response when its transfer is accepted. A clocked monitor checks each
// response field by field against the oldest prediction. Phases cover the
// default table under different option counts, directed corner loads, and
// random load/sample traffic with varying input gaps.
// ----------------------------------------------------------------------------
module weighted_choice_table_tb;
  import wct_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 4000000;
  localparam logic [ADDR_W-1:0] ADDR_OPTION_COUNT = ADDR_W'({REG_OPTION_COUNT, 2'b00});
  localparam logic [ADDR_W-1:0] ADDR_SPARE = 3'd4;
  localparam logic [SEL_W-1:0] SEL_MAX = {SEL_W{1'b1}};

  typedef enum logic [1:0] {
    SEL_FIXED,
    SEL_UNDER,
    SEL_TOP,
    SEL_OVER
  } sel_kind_t;

  typedef struct {
    logic                   opcode;
    logic [IN_WEIGHT_W-1:0] weight;
    logic                   last;
    logic [SEL_W-1:0]       selector;
    sel_kind_t              kind;
  } command_t;

  typedef struct {
    logic [IDX_OUT_W-1:0]   chosen;
    logic [TOTAL_OUT_W-1:0] total;
    logic [DIV_OUT_W-1:0]   divisor;
    logic [STATUS_W-1:0]    status;
  } response_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   start = 1'b0;
  logic                   busy;
  logic                   in_opcode = OP_LOAD;
  logic [IN_WEIGHT_W-1:0] in_weight_value = '0;
  logic                   in_last_weight = 1'b0;
  logic [SEL_W-1:0]       in_selector = '0;
  logic                   out_valid;
  logic [IDX_OUT_W-1:0]   out_chosen_index;
  logic [TOTAL_OUT_W-1:0] out_total_weight;
  logic [DIV_OUT_W-1:0]   out_common_divisor;
  logic [STATUS_W-1:0]    out_status;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [ADDR_W-1:0]      paddr = '0;
  logic [DATA_W-1:0]      pwdata = '0;
  logic [DATA_W-1:0]      prdata;
  logic                   pready;

  command_t  command_queue[$];
  response_t due_responses[$];
  command_t  on_port;
  int        idle_pct = 0;
  int        burst_left = 0;
  int        errors = 0;
  int unsigned cycles = 0;

  // table model
  logic [IN_WEIGHT_W-1:0] staged_w[MAX_CHOICES];
  int                     staged_cnt = 0;
  logic [IN_WEIGHT_W-1:0] table_w[MAX_CHOICES];
  int                     table_cnt = 0;
  logic                   table_loaded = 1'b0;
  logic [19:0]            table_sum = '0;
  logic [DIV_OUT_W-1:0]   applied_divisor = DIV_OUT_W'(1);
  logic [OPT_W-1:0]       option_count = OPT_RESET;

  weighted_choice_table uut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_opcode(in_opcode),
    .in_weight_value(in_weight_value),
    .in_last_weight(in_last_weight),
    .in_selector(in_selector),
    .out_valid(out_valid),
    .out_chosen_index(out_chosen_index),
    .out_total_weight(out_total_weight),
    .out_common_divisor(out_common_divisor),
    .out_status(out_status),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic logic [19:0] table_total();
    if (table_loaded) return table_sum;
    return (option_count > MAX_CHOICES) ? 20'(MAX_CHOICES) : 20'(option_count);
  endfunction

  function automatic command_t fix_selector(input command_t c);
    logic [19:0] tot;
    logic [19:0] sel;
    tot = table_total();
    sel = 20'(c.selector);
    case (c.kind)
      SEL_UNDER: begin
        sel = (tot != 0) ? 20'($urandom % tot) : 20'($urandom_range(0, SEL_MAX));
      end
      SEL_TOP: begin
        sel = (tot != 0) ? tot - 20'd1 : '0;
      end
      SEL_OVER: begin
        sel = tot + 20'($urandom_range(0, 3));
        if (sel > 20'(SEL_MAX)) sel = 20'(SEL_MAX);
      end
      default: ;
    endcase
    c.selector = sel[SEL_W-1:0];
    return c;
  endfunction

  // advances the table model by one command and queues its response
  function automatic void step_table(input command_t c);
    response_t   r;
    logic [19:0] tot;
    logic [19:0] left;
    logic [19:0] sum;
    logic [IN_WEIGHT_W-1:0] g;
    logic [IN_WEIGHT_W-1:0] a;
    logic [IN_WEIGHT_W-1:0] b;
    logic [IN_WEIGHT_W-1:0] t;
    logic [IN_WEIGHT_W-1:0] w;
    int n;
    r.chosen = '0;
    r.status = STATUS_OK;
    if (c.opcode == OP_LOAD) begin
      if (staged_cnt < MAX_CHOICES) begin
        staged_w[staged_cnt] = c.weight;
        staged_cnt++;
      end else begin
        r.status = STATUS_OVERFLOW;
      end
      if (c.last) begin
        g = '0;
        for (int i = 0; i < staged_cnt; i++) begin
          a = g;
          b = staged_w[i];
          while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
          end
          g = a;
        end
        if (g == 0) g = IN_WEIGHT_W'(1);
        sum = '0;
        for (int i = 0; i < staged_cnt; i++) begin
          table_w[i] = staged_w[i] / g;
          sum += 20'(table_w[i]);
        end
        table_cnt = staged_cnt;
        table_sum = sum;
        applied_divisor = g;
        table_loaded = 1'b1;
        staged_cnt = 0;
      end
    end else begin
      tot = table_total();
      if (tot == 0 || 20'(c.selector) >= tot) begin
        r.status = STATUS_RANGE;
      end else begin
        n = table_loaded ? table_cnt : int'(tot);
        left = 20'(c.selector);
        for (int i = 0; i < n; i++) begin
          w = table_loaded ? table_w[i] : IN_WEIGHT_W'(1);
          if (20'(w) > left) begin
            r.chosen = IDX_OUT_W'(i);
            break;
          end
          left -= 20'(w);
        end
      end
    end
    r.total = TOTAL_OUT_W'(table_total());
    r.divisor = applied_divisor;
    due_responses.insert(due_responses.size(), r);
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) step_table(on_port);
      if (!start || !busy) begin
        if (burst_left != 0) burst_left--;
        else if ($urandom_range(0, 49) == 0) burst_left = $urandom_range(10, 40);
        if (command_queue.size() != 0 &&
            (burst_left != 0 || $urandom_range(0, 99) >= idle_pct)) begin
          on_port = fix_selector(command_queue.pop_front());
          start <= 1'b1;
          in_opcode <= on_port.opcode;
          in_weight_value <= on_port.weight;
          in_last_weight <= on_port.last;
          in_selector <= on_port.selector;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    response_t e;
    if (rst_n && out_valid) begin
      if (due_responses.size() == 0) begin
        $error("response transfer with nothing outstanding");
        errors++;
      end else begin
        e = due_responses.pop_front();
        if (out_chosen_index !== e.chosen) begin
          $error("chosen_index: expected %0d, got %0d", e.chosen, out_chosen_index);
          errors++;
        end
        if (out_total_weight !== e.total) begin
          $error("total_weight: expected %0d, got %0d", e.total, out_total_weight);
          errors++;
        end
        if (out_common_divisor !== e.divisor) begin
          $error("common_divisor: expected %0d, got %0d", e.divisor, out_common_divisor);
          errors++;
        end
        if (out_status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, out_status);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic push_load(input logic [IN_WEIGHT_W-1:0] w, input logic last);
    command_t c;
    c.opcode = OP_LOAD;
    c.weight = w;
    c.last = last;
    c.selector = SEL_W'($urandom);
    c.kind = SEL_FIXED;
    command_queue.insert(command_queue.size(), c);
  endtask

  task automatic push_sample(input sel_kind_t kind, input logic [SEL_W-1:0] sel);
    command_t c;
    c.opcode = OP_SAMPLE;
    c.weight = IN_WEIGHT_W'($urandom);
    c.last = 1'($urandom);
    c.selector = sel;
    c.kind = kind;
    command_queue.insert(command_queue.size(), c);
  endtask

  task automatic push_random_sample();
    int p;
    p = $urandom_range(0, 99);
    if (p < 70) push_sample(SEL_UNDER, '0);
    else if (p < 80) push_sample(SEL_TOP, '0);
    else if (p < 90) push_sample(SEL_OVER, '0);
    else push_sample(SEL_FIXED, SEL_W'($urandom));
  endtask

  task automatic push_table(input int n, input int style, input logic close);
    logic [IN_WEIGHT_W-1:0] factor;
    logic [IN_WEIGHT_W-1:0] w;
    factor = IN_WEIGHT_W'($urandom_range(1, 4095));
    for (int i = 0; i < n; i++) begin
      case (style)
        0: w = '0;
        1: w = IN_WEIGHT_W'($urandom_range(0, 15));
        2: w = factor * IN_WEIGHT_W'($urandom_range(0, 15));
        3: w = IN_WEIGHT_W'(1) << $urandom_range(0, IN_WEIGHT_W - 1);
        default: w = IN_WEIGHT_W'($urandom);
      endcase
      push_load(w, close && (i == n - 1));
    end
  endtask

  task automatic drain();
    while (command_queue.size() != 0 || start || due_responses.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [OPT_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= {(DATA_W - OPT_W)'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr[ADDR_W-1:2] == REG_OPTION_COUNT) option_count = value;
  endtask

  initial begin
    int idle_plan[3];
    int made;
    int p;
    int n;
    idle_plan = '{0, 69, 15};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // default table at reset size and under other option counts
    push_sample(SEL_FIXED, '0);
    push_sample(SEL_FIXED, 19'd8);
    push_sample(SEL_FIXED, SEL_MAX);
    drain();
    write_reg(ADDR_OPTION_COUNT, 4'd0);
    push_sample(SEL_FIXED, '0);
    drain();
    write_reg(ADDR_OPTION_COUNT, 4'd15);
    push_sample(SEL_TOP, '0);
    push_sample(SEL_OVER, '0);
    drain();
    write_reg(ADDR_OPTION_COUNT, 4'd1);
    push_sample(SEL_FIXED, '0);
    drain();
    write_reg(ADDR_SPARE, 4'd0);
    push_sample(SEL_FIXED, '0);
    drain();
    write_reg(ADDR_OPTION_COUNT, 4'd5);
    push_sample(SEL_UNDER, '0);
    push_sample(SEL_TOP, '0);

    // all-zero table, overflowing load, gcd with zero entries
    push_load('0, 1'b0);
    push_load('0, 1'b1);
    push_sample(SEL_FIXED, '0);
    for (int i = 0; i < MAX_CHOICES; i++) push_load('1, 1'b0);
    push_load(16'd123, 1'b1);
    push_sample(SEL_TOP, '0);
    push_load(16'd0, 1'b0);
    push_load(16'd6, 1'b0);
    push_load(16'd0, 1'b0);
    push_load(16'd9, 1'b1);
    push_sample(SEL_FIXED, 19'd0);
    push_sample(SEL_FIXED, 19'd2);
    push_sample(SEL_FIXED, 19'd5);
    drain();

    foreach (idle_plan[k]) begin
      write_reg(ADDR_OPTION_COUNT, (k == 0) ? 4'd15 : OPT_W'($urandom));
      idle_pct = idle_plan[k];
      made = 0;
      while (made < 360) begin
        p = $urandom_range(0, 99);
        if (p < 80) begin
          n = $urandom_range(1, MAX_CHOICES);
          push_table(n, $urandom_range(0, 5), 1'b1);
          made += n;
          n = $urandom_range(1, 8);
          repeat (n) push_random_sample();
          made += n;
        end else if (p < 87) begin
          n = MAX_CHOICES + $urandom_range(1, 3);
          push_table(n, $urandom_range(1, 5), 1'b1);
          push_random_sample();
          made += n + 1;
        end else if (p < 93) begin
          n = $urandom_range(1, 4);
          push_table(n, $urandom_range(1, 5), 1'b0);
          made += n;
        end else begin
          if ($urandom_range(0, 1) == 0) push_load(IN_WEIGHT_W'($urandom), 1'($urandom));
          else push_sample(SEL_FIXED, SEL_W'($urandom));
          made++;
        end
      end
      drain();
    end
    write_reg(ADDR_OPTION_COUNT, 4'd0);

    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: weighted_choice_table.f
rtl/wct_pkg.sv
rtl/wct_gcd.sv
rtl/wct_cell.sv
rtl/weighted_choice_table.sv
verif/weighted_choice_table_tb.sv
